// ===== rtl/cse_pkg.sv =====
// Shared constants and controller/datapath interface types for the cosine similarity engine.
package cse_pkg;

  localparam int FIELD_W   = 16;
  localparam int ELEM_BITS = 16;
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int ACC_W     = 48;
  localparam int WORK_W    = 64;
  localparam int ROOT_W    = WORK_W / 2;
  localparam int SHIFT_W   = 5;
  localparam int STEP_W    = 7;
  localparam int SIM_W     = 16;
  localparam int FRAC_BITS = 15;
  localparam int Q_W       = FRAC_BITS + 2;

  localparam logic [Q_W-1:0] LIM_NEG = Q_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] LIM_POS = LIM_NEG - Q_W'(1);

  typedef struct packed {
    logic capture;
    logic load;
    logic norm_step;
    logic root_init;
    logic root_step;
    logic mul;
    logic div_step;
    logic res_load;
  } cse_cmd_t;

  typedef struct packed {
    logic zero_norm;
    logic norm_done;
    logic root_done;
    logic div_done;
    logic out_free;
  } cse_stat_t;

endpackage

// ===== rtl/cse_ctrl.sv =====
// Control state machine for accumulation, norm scaling, roots, multiply and divide.
module cse_ctrl import cse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_elem,
  input  cse_stat_t stat,
  output logic      in_stall,
  output cse_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_ACCUM = 8'b0000_0001,
    S_DRAIN = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_NORM  = 8'b0000_1000,
    S_ROOT  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_ACCUM);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_ACCUM: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_last_elem) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (stat.zero_norm) begin
          state_nxt = S_OUT;
        end else if (stat.norm_done) begin
          cmd.root_init = 1'b1;
          state_nxt     = S_ROOT;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_ROOT: begin
        if (stat.root_done) begin
          state_nxt = S_MUL;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_ACCUM;
        end
      end
      default: begin
        state_nxt = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/cse_dpath.sv =====
// Datapath with the product stage, saturating sums, norm scaling, square roots and divider.
module cse_dpath import cse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic        [FIELD_W-1:0] elem_a,
  input  logic        [FIELD_W-1:0] elem_b,
  input  cse_cmd_t                 cmd,
  output cse_stat_t                stat,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [SIM_W-1:0]  out_similarity,
  output logic                     out_zero_norm
);

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - PROD_W){p[PROD_W-1]}}, p};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  logic signed [ELEM_BITS-1:0] a_s, b_s;
  logic signed [PROD_W-1:0]    pab_r, paa_r, pbb_r;
  logic                        p_vld_r;
  logic signed [ACC_W-1:0]     dot_r, na_acc_r, nb_acc_r;
  logic        [ACC_W-1:0]     dot_mag;
  logic        [WORK_W-1:0]    na_w_r, nb_w_r;
  logic        [SHIFT_W-1:0]   ka_r, kb_r;
  logic        [ACC_W-1:0]     mag_r;
  logic                        neg_r, zero_r;
  logic        [WORK_W-1:0]    xa_r, xb_r, ra_r, rb_r, bit_r;
  logic        [WORK_W-1:0]    ta, tb;
  logic        [WORK_W-1:0]    den_r, rem_r;
  logic        [WORK_W:0]      rem2, den_ext;
  logic        [STEP_W-1:0]    div_cnt_r;
  logic        [Q_W-1:0]       q_r, limit, q_sat;
  logic                        over;
  logic        [SIM_W-1:0]     mag16, sim;
  logic                        out_valid_r, out_zn_r;
  logic signed [SIM_W-1:0]     out_sim_r;

  assign a_s = elem_a[ELEM_BITS-1:0];
  assign b_s = elem_b[ELEM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.capture;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pab_r <= a_s * b_s;
      paa_r <= a_s * a_s;
      pbb_r <= b_s * b_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      dot_r    <= '0;
      na_acc_r <= '0;
      nb_acc_r <= '0;
    end else if (p_vld_r) begin
      dot_r    <= sat_add(dot_r, pab_r);
      na_acc_r <= sat_add(na_acc_r, paa_r);
      nb_acc_r <= sat_add(nb_acc_r, pbb_r);
    end
  end

  assign dot_mag = dot_r[ACC_W-1] ? ACC_W'(-dot_r) : ACC_W'(dot_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      na_w_r <= {{(WORK_W - ACC_W){1'b0}}, na_acc_r};
      nb_w_r <= {{(WORK_W - ACC_W){1'b0}}, nb_acc_r};
      ka_r   <= '0;
      kb_r   <= '0;
      mag_r  <= dot_mag;
      neg_r  <= dot_r[ACC_W-1];
      zero_r <= (na_acc_r == '0) || (nb_acc_r == '0);
    end else if (cmd.norm_step) begin
      if (na_w_r[WORK_W-1 -: 2] == 2'b00) begin
        na_w_r <= na_w_r << 2;
        ka_r   <= ka_r + SHIFT_W'(1);
      end
      if (nb_w_r[WORK_W-1 -: 2] == 2'b00) begin
        nb_w_r <= nb_w_r << 2;
        kb_r   <= kb_r + SHIFT_W'(1);
      end
    end
  end

  assign ta = ra_r + bit_r;
  assign tb = rb_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.root_init) begin
      bit_r <= WORK_W'(1) << (WORK_W - 2);
    end else if (cmd.root_step) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      xa_r <= na_w_r;
      xb_r <= nb_w_r;
      ra_r <= '0;
      rb_r <= '0;
    end else if (cmd.root_step) begin
      if (xa_r >= ta) begin
        xa_r <= xa_r - ta;
        ra_r <= (ra_r >> 1) + bit_r;
      end else begin
        ra_r <= ra_r >> 1;
      end
      if (xb_r >= tb) begin
        xb_r <= xb_r - tb;
        rb_r <= (rb_r >> 1) + bit_r;
      end else begin
        rb_r <= rb_r >> 1;
      end
    end
  end

  assign rem2    = {rem_r, 1'b0};
  assign den_ext = {1'b0, den_r};
  assign limit   = neg_r ? LIM_NEG : LIM_POS;
  assign over    = (q_r > limit);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den_r     <= ra_r[ROOT_W-1:0] * rb_r[ROOT_W-1:0];
      div_cnt_r <= STEP_W'(FRAC_BITS) + STEP_W'(ka_r) + STEP_W'(kb_r);
      rem_r     <= {{(WORK_W - ACC_W){1'b0}}, mag_r};
      q_r       <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= den_ext) begin
        rem_r <= WORK_W'(rem2 - den_ext);
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_r <= rem2[WORK_W-1:0];
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r - STEP_W'(1);
    end
  end

  assign q_sat = over ? limit : q_r;
  assign mag16 = q_sat[SIM_W-1:0];
  assign sim   = neg_r ? SIM_W'(-mag16) : mag16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_sim_r <= zero_r ? '0 : sim;
      out_zn_r  <= zero_r;
    end
  end

  assign stat.zero_norm = zero_r;
  assign stat.norm_done = (na_w_r[WORK_W-1 -: 2] != 2'b00) && (nb_w_r[WORK_W-1 -: 2] != 2'b00);
  assign stat.root_done = (bit_r == '0);
  assign stat.div_done  = (div_cnt_r == '0) || over;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;
  assign out_zero_norm  = out_zn_r;

endmodule

// ===== rtl/cosine_similarity_engine.sv =====
// Top level of the streaming cosine similarity engine.
//
// The input channel carries one element pair of two Q4.12 vectors per transfer,
// with in_last_elem marking the final pair. The engine keeps saturating sums of
// a*b, a*a and b*b and takes one pair per cycle while a vector streams in.
// After the last pair it stops taking pairs and computes dot / sqrt(na * nb):
// each norm is scaled by an even power of two, two bit-serial square roots run
// side by side, one 32x32 multiply forms the denominator and a restoring
// divider produces one quotient bit per cycle. The result reaches the output
// channel after the root and divide loops finish; a zero norm skips them and
// gives a result with out_zero_norm set and out_similarity at zero.
// The result sits in an output register; once it is loaded the engine takes
// the next vector at once, even while the receiver stalls. A second result
// waits inside the engine until the register is free.
// Reset clears the sums, the output valid flag and the controller.
module cosine_similarity_engine import cse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [FIELD_W-1:0] in_elem_a,
  input  logic signed [FIELD_W-1:0] in_elem_b,
  input  logic                     in_last_elem,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SIM_W-1:0]  out_similarity,
  output logic                     out_zero_norm
);

  cse_cmd_t  cmd;
  cse_stat_t stat;

  cse_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_elem (in_last_elem),
    .stat         (stat),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  cse_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .elem_a         (in_elem_a),
    .elem_b         (in_elem_b),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_similarity (out_similarity),
    .out_zero_norm  (out_zero_norm)
  );

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_elem) |=> in_stall)
    else $error("Input was not stalled after the last pair's transfer.");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_norm) |-> (out_similarity == '0))
    else $error("A zero norm result carries a nonzero similarity.");

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("A result was loaded while the input side was open.");

endmodule
